// ----- design/json_string_unescape_utf8_defines.svh -----
// Assertion macros used by the JSON string unescaper burst queue.
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`ifndef SYNTH
`define JSU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("jsu: assertion failed");
`define JSU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jsu: assertion failed");
`else
`define JSU_ASSERT_IMP(lbl, ante, cons)
`define JSU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- design/jsu_pkg.sv -----
// Types, constants and helper functions for the JSON string unescaper.
package jsu_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);
  localparam int unsigned MAXRES = 6;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;

  typedef enum logic [2:0] {
    ST_BYTE     = 3'd0,
    ST_DONE     = 3'd1,
    ST_NO_QUOTE = 3'd2,
    ST_UNTERM   = 3'd3,
    ST_UNT_ESC  = 3'd4,
    ST_BAD_ESC  = 3'd5,
    ST_BAD_UNI  = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    status_e    st;
  } res_t;

  typedef struct packed {
    logic [2:0]            cnt;
    res_t [MAXRES-1:0]     res;
  } burst_t;

  typedef struct packed {
    logic [2:0]      cnt;
    logic [3:0][7:0] b;
  } enc_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] ch;
  } esc_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] v;
  } hex_t;

  function automatic enc_t utf8_enc(logic [20:0] c);
    enc_t e;
    e = '0;
    if (c < 21'h80) begin
      e.cnt  = 3'd1;
      e.b[0] = c[7:0];
    end else if (c < 21'h800) begin
      e.cnt  = 3'd2;
      e.b[0] = {3'b110, c[10:6]};
      e.b[1] = {2'b10, c[5:0]};
    end else if (c < 21'h10000) begin
      e.cnt  = 3'd3;
      e.b[0] = {4'b1110, c[15:12]};
      e.b[1] = {2'b10, c[11:6]};
      e.b[2] = {2'b10, c[5:0]};
    end else begin
      e.cnt  = 3'd4;
      e.b[0] = {5'b11110, c[20:18]};
      e.b[1] = {2'b10, c[17:12]};
      e.b[2] = {2'b10, c[11:6]};
      e.b[3] = {2'b10, c[5:0]};
    end
    return e;
  endfunction

  function automatic hex_t hex_val(logic [7:0] b);
    hex_t h;
    h = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.ok = 1'b1;
      h.v  = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.ok = 1'b1;
      h.v  = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.ok = 1'b1;
      h.v  = 4'(b - 8'h37);
    end
    return h;
  endfunction

  function automatic esc_t esc_map(logic [7:0] b);
    esc_t e;
    e.ok = 1'b1;
    case (b)
      CH_QUOTE:  e.ch = CH_QUOTE;
      CH_BSLASH: e.ch = CH_BSLASH;
      CH_SLASH:  e.ch = CH_SLASH;
      8'h62:     e.ch = 8'h08;
      8'h66:     e.ch = 8'h0C;
      8'h6E:     e.ch = 8'h0A;
      8'h72:     e.ch = 8'h0D;
      8'h74:     e.ch = 8'h09;
      default: begin
        e.ok = 1'b0;
        e.ch = 8'h00;
      end
    endcase
    return e;
  endfunction

endpackage

// ----- design/jsu_if.sv -----
// Valid/ready channel interfaces for text input and decoded output.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_byte;

  modport source (output valid, output kind, output in_byte, input ready);
  modport sink (input valid, input kind, input in_byte, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface

// ----- design/jsu_front.sv -----
// Front end: string/escape state machine that turns one input transfer into a result burst.
module jsu_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  jsu_in_if.sink           in_i,
  input  logic             q_full_i,
  output logic             push_o,
  output jsu_pkg::burst_t  burst_o
);

  typedef enum logic [3:0] {
    M_IDLE, M_BODY, M_ESC, M_HEX, M_PEND, M_PENDU, M_LOWHEX, M_DRAIN
  } mode_e;

  mode_e       mode_q, mode_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] acc_q, acc_d;
  logic [9:0]  hp_q, hp_d;

  logic            fl, raw, utf, st_en;
  logic [7:0]      b, raw_b;
  logic [20:0]     code;
  jsu_pkg::status_e st;
  jsu_pkg::hex_t   hx;
  jsu_pkg::esc_t   es;
  logic [15:0]     acc_n;
  jsu_pkg::enc_t   enc;
  jsu_pkg::burst_t bst;
  logic [2:0]      n;
  logic            take;

  assign b     = in_i.in_byte;
  assign hx    = jsu_pkg::hex_val(b);
  assign es    = jsu_pkg::esc_map(b);
  assign acc_n = {acc_q[11:0], hx.v};
  assign take  = in_i.valid && in_i.ready;

  assign in_i.ready = !q_full_i;

  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    hp_d   = hp_q;
    fl     = 1'b0;
    raw    = 1'b0;
    raw_b  = b;
    utf    = 1'b0;
    code   = '0;
    st_en  = 1'b0;
    st     = jsu_pkg::ST_DONE;
    if (in_i.kind) begin
      st_en = 1'b1;
      case (mode_q)
        M_IDLE:   st = jsu_pkg::ST_NO_QUOTE;
        M_BODY:   st = jsu_pkg::ST_UNTERM;
        M_ESC:    st = jsu_pkg::ST_UNT_ESC;
        M_HEX:    st = jsu_pkg::ST_BAD_UNI;
        M_PEND: begin
          fl = 1'b1;
          st = jsu_pkg::ST_UNTERM;
        end
        M_PENDU: begin
          fl = 1'b1;
          st = jsu_pkg::ST_UNT_ESC;
        end
        M_LOWHEX: begin
          fl = 1'b1;
          st = jsu_pkg::ST_BAD_UNI;
        end
        default: st_en = 1'b0;
      endcase
      mode_d = M_IDLE;
      cnt_d  = '0;
      acc_d  = '0;
      hp_d   = '0;
    end else begin
      case (mode_q)
        M_IDLE: begin
          if (b == jsu_pkg::CH_QUOTE) begin
            mode_d = M_BODY;
          end else begin
            st_en  = 1'b1;
            st     = jsu_pkg::ST_NO_QUOTE;
            mode_d = M_DRAIN;
          end
        end
        M_BODY, M_PEND: begin
          if (mode_q == M_PEND && b == jsu_pkg::CH_BSLASH) begin
            mode_d = M_PENDU;
          end else begin
            fl = (mode_q == M_PEND);
            if (b == jsu_pkg::CH_QUOTE) begin
              st_en  = 1'b1;
              st     = jsu_pkg::ST_DONE;
              mode_d = M_DRAIN;
            end else if (b == jsu_pkg::CH_BSLASH) begin
              mode_d = M_ESC;
            end else begin
              raw    = 1'b1;
              mode_d = M_BODY;
            end
          end
        end
        M_ESC, M_PENDU: begin
          if (mode_q == M_PENDU && b == jsu_pkg::CH_U) begin
            mode_d = M_LOWHEX;
            cnt_d  = '0;
            acc_d  = '0;
          end else begin
            fl = (mode_q == M_PENDU);
            if (es.ok) begin
              raw    = 1'b1;
              raw_b  = es.ch;
              mode_d = M_BODY;
            end else if (b == jsu_pkg::CH_U) begin
              mode_d = M_HEX;
              cnt_d  = '0;
              acc_d  = '0;
            end else begin
              st_en  = 1'b1;
              st     = jsu_pkg::ST_BAD_ESC;
              mode_d = M_DRAIN;
            end
          end
        end
        M_HEX, M_LOWHEX: begin
          if (!hx.ok) begin
            fl     = (mode_q == M_LOWHEX);
            st_en  = 1'b1;
            st     = jsu_pkg::ST_BAD_UNI;
            mode_d = M_DRAIN;
          end else begin
            acc_d = acc_n;
            if (cnt_q != 2'd3) begin
              cnt_d = cnt_q + 2'd1;
            end else if (mode_q == M_LOWHEX && acc_n[15:10] == 6'b110111) begin
              utf    = 1'b1;
              code   = {11'd64 + {1'b0, hp_q}, acc_n[9:0]};
              mode_d = M_BODY;
            end else begin
              fl = (mode_q == M_LOWHEX);
              if (acc_n[15:10] == 6'b110110) begin
                hp_d   = acc_n[9:0];
                mode_d = M_PEND;
              end else begin
                utf    = 1'b1;
                code   = {5'd0, acc_n};
                mode_d = M_BODY;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Burst assembly: pending high surrogate, then the character, then the status.
  assign enc = jsu_pkg::utf8_enc(code);

  always_comb begin
    bst = '0;
    n   = '0;
    if (fl) begin
      bst.res[0] = '{data: 8'hED, st: jsu_pkg::ST_BYTE};
      bst.res[1] = '{data: {4'b1010, hp_q[9:6]}, st: jsu_pkg::ST_BYTE};
      bst.res[2] = '{data: {2'b10, hp_q[5:0]}, st: jsu_pkg::ST_BYTE};
      n = 3'd3;
    end
    if (raw) begin
      bst.res[n] = '{data: raw_b, st: jsu_pkg::ST_BYTE};
      n = n + 3'd1;
    end
    if (utf) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < enc.cnt) begin
          bst.res[n + 3'(i)] = '{data: enc.b[i], st: jsu_pkg::ST_BYTE};
        end
      end
      n = n + enc.cnt;
    end
    if (st_en) begin
      bst.res[n] = '{data: 8'h00, st: st};
      n = n + 3'd1;
    end
    bst.cnt = n;
  end

  assign burst_o = bst;
  assign push_o  = take && (bst.cnt != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      cnt_q  <= '0;
      acc_q  <= '0;
      hp_q   <= '0;
    end else if (take) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      hp_q   <= hp_d;
    end
  end

endmodule

// ----- design/jsu_queue.sv -----
// Short burst queue between the front end and the output serializer.
`include "json_string_unescape_utf8_defines.svh"

module jsu_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  jsu_pkg::burst_t  data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output jsu_pkg::burst_t  data_o
);

  jsu_pkg::burst_t                  mem_q [jsu_pkg::QDEPTH];
  logic [jsu_pkg::QAW-1:0]          wp_q, rp_q;
  logic [jsu_pkg::QCW-1:0]          cnt_q;

  assign full_o  = (cnt_q == jsu_pkg::QCW'(jsu_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `JSU_ASSERT_IMP(q_no_overflow, push_i, !full_o)
  `JSU_ASSERT_IMP(q_no_underflow, pop_i, !empty_o)
  `JSU_ASSERT_IMP(q_nonempty_burst, push_i, data_i.cnt != 3'd0)
  `JSU_ASSERT_NXT(q_count_up, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1)

endmodule

// ----- design/jsu_back.sv -----
// Back end: serializes queued bursts into single output transfers.
module jsu_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  jsu_pkg::burst_t  head_i,
  input  logic             empty_i,
  output logic             pop_o,
  jsu_out_if.source        out_o
);

  logic [2:0]  idx_q;
  logic        ov_q;
  logic [7:0]  ob_q;
  logic [2:0]  os_q;
  logic        ol_q;
  logic        load, fin;
  jsu_pkg::res_t cur;

  assign cur   = head_i.res[idx_q];
  assign load  = !empty_i && (!ov_q || out_o.ready);
  assign fin   = (idx_q == head_i.cnt - 3'd1);
  assign pop_o = load && fin;

  assign out_o.valid    = ov_q;
  assign out_o.out_byte = ob_q;
  assign out_o.status   = os_q;
  assign out_o.last     = ol_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      ob_q <= cur.data;
      os_q <= cur.st;
      ol_q <= fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      idx_q <= '0;
    end else begin
      if (load) begin
        ov_q  <= 1'b1;
        idx_q <= fin ? 3'd0 : idx_q + 3'd1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

endmodule

// ----- design/json_string_unescape_utf8.sv -----
// Top level of the streaming JSON string unescaper with UTF-8 output.
//
// in_i takes one transfer per text byte (kind 0) or an end-of-text mark (kind 1).
// out_o gives decoded UTF-8 bytes (status 0) and status items; last marks the
// final result caused by an input transfer. An input may cause zero to six
// results; one that causes none (opening quote, escape prefix, hex digit,
// bytes being discarded) leaves nothing on out_o.
// Each input's results pass through the burst queue and the output register to out_o.
// Throughput: one input transfer per cycle while the 4-entry burst queue has
// room; out_o gives one result per cycle while out_o.ready is high, so the output
// side sets the sustained rate when inputs expand to several bytes.
// Reset (rst_ni low, asynchronous) returns the decoder to waiting for an opening
// quote and empties the queue and the output register.
// When out_o.ready is low the result holds in the output register, the queue
// fills, and in_i.ready drops once the queue is full.
module json_string_unescape_utf8 (
  input  logic       clk_i,
  input  logic       rst_ni,
  jsu_in_if.sink     in_i,
  jsu_out_if.source  out_o
);

  logic            push, pop, full, empty;
  jsu_pkg::burst_t wr_burst, rd_burst;

  jsu_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (full),
    .push_o   (push),
    .burst_o  (wr_burst)
  );

  jsu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (wr_burst),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (rd_burst)
  );

  jsu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (rd_burst),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ----- bench/tb_json_string_unescape_utf8.sv -----
// Testbench for the JSON string unescaper: directed rows, a stalled-output text, then random texts.
module tb_json_string_unescape_utf8;

  localparam int CYCLE_LIMIT = 400000;
  localparam int N_ITEMS     = 130;
  localparam int MAX_REPORT  = 10;
  localparam int TAIL_CYCLES = 20;
  localparam int LONG_HOLD   = 60;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0][7:0] ESC_LIST = {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH,
                                          jsu_pkg::CH_SLASH, CH_B,
                                          CH_F, CH_N, CH_R, CH_T};

  typedef enum logic [3:0] {
    DM_IDLE, DM_BODY, DM_ESC, DM_HEX, DM_PEND, DM_PENDU, DM_LOWHEX, DM_DRAIN
  } dec_mode_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] b;
  } text_item_t;

  typedef struct packed {
    logic [7:0]       data;
    jsu_pkg::status_e st;
    logic             last;
  } dec_res_t;

  typedef struct packed {
    text_item_t item;
    logic       typed;
    dec_res_t   want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_utf8 DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  dec_mode_e   dec_mode   = DM_IDLE;
  logic [1:0]  dec_hex_n  = '0;
  logic [15:0] dec_code   = '0;
  logic [9:0]  dec_high   = '0;

  dec_res_t    step_q[$];
  dec_res_t    decoded_q[$];
  text_item_t  text_q[$];
  dir_row_t    dir_tab [25];

  int n_bad      = 0;
  int n_sent     = 0;
  int n_cycles   = 0;
  int rx_wait    = 0;
  int rx_hold    = 0;
  bit tx_quiet   = 1'b0;
  bit rx_quiet   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int draw_gap(input bit quiet);
    if (quiet || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 16);
  endfunction

  // decoder model

  function automatic void put_res(input logic [7:0] d, input jsu_pkg::status_e s);
    dec_res_t r;
    r.data = d;
    r.st   = s;
    r.last = 1'b0;
    step_q = {step_q, r};
  endfunction

  function automatic void fail_to(input jsu_pkg::status_e s);
    put_res(8'h00, s);
    dec_mode = DM_DRAIN;
  endfunction

  function automatic void put_utf8(input logic [20:0] c);
    if (c < 21'h80) begin
      put_res(c[7:0], jsu_pkg::ST_BYTE);
    end else if (c < 21'h800) begin
      put_res(8'hC0 | 8'(c >> 6), jsu_pkg::ST_BYTE);
      put_res(8'h80 | 8'(c & 21'h3F), jsu_pkg::ST_BYTE);
    end else if (c < 21'h10000) begin
      put_res(8'hE0 | 8'(c >> 12), jsu_pkg::ST_BYTE);
      put_res(8'h80 | 8'((c >> 6) & 21'h3F), jsu_pkg::ST_BYTE);
      put_res(8'h80 | 8'(c & 21'h3F), jsu_pkg::ST_BYTE);
    end else begin
      put_res(8'hF0 | 8'((c >> 18) & 21'h7), jsu_pkg::ST_BYTE);
      put_res(8'h80 | 8'((c >> 12) & 21'h3F), jsu_pkg::ST_BYTE);
      put_res(8'h80 | 8'((c >> 6) & 21'h3F), jsu_pkg::ST_BYTE);
      put_res(8'h80 | 8'(c & 21'h3F), jsu_pkg::ST_BYTE);
    end
  endfunction

  function automatic void flush_high();
    put_utf8(21'hD800 + 21'(dec_high));
  endfunction

  function automatic int hex_digit(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
    if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
    if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
    return -1;
  endfunction

  function automatic bit simple_escape(input logic [7:0] b, output logic [7:0] ch);
    ch = 8'h00;
    case (b)
      jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: ch = b;
      CH_B: ch = 8'h08;
      CH_F: ch = 8'h0C;
      CH_N: ch = 8'h0A;
      CH_R: ch = 8'h0D;
      CH_T: ch = 8'h09;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void body_byte(input logic [7:0] b);
    if (b == jsu_pkg::CH_QUOTE) begin
      put_res(8'h00, jsu_pkg::ST_DONE);
      dec_mode = DM_DRAIN;
    end else if (b == jsu_pkg::CH_BSLASH) begin
      dec_mode = DM_ESC;
    end else begin
      put_res(b, jsu_pkg::ST_BYTE);
    end
  endfunction

  function automatic void esc_byte(input logic [7:0] b);
    logic [7:0] ch;
    if (b == jsu_pkg::CH_U) begin
      dec_mode  = DM_HEX;
      dec_hex_n = '0;
      dec_code  = '0;
    end else if (simple_escape(b, ch)) begin
      put_res(ch, jsu_pkg::ST_BYTE);
      dec_mode = DM_BODY;
    end else begin
      fail_to(jsu_pkg::ST_BAD_ESC);
    end
  endfunction

  function automatic void finish_code(input logic [15:0] c);
    if (c >= 16'hD800 && c <= 16'hDBFF) begin
      dec_high = c[9:0];
      dec_mode = DM_PEND;
    end else begin
      put_utf8(21'(c));
      dec_mode = DM_BODY;
    end
  endfunction

  function automatic void text_in(input logic [7:0] b);
    int v;
    case (dec_mode)
      DM_IDLE: begin
        if (b == jsu_pkg::CH_QUOTE) dec_mode = DM_BODY;
        else fail_to(jsu_pkg::ST_NO_QUOTE);
      end
      DM_BODY: body_byte(b);
      DM_ESC:  esc_byte(b);
      DM_HEX: begin
        v = hex_digit(b);
        if (v < 0) begin
          fail_to(jsu_pkg::ST_BAD_UNI);
        end else begin
          dec_code = {dec_code[11:0], 4'(v)};
          if (dec_hex_n == 2'd3) finish_code(dec_code);
          else dec_hex_n++;
        end
      end
      DM_PEND: begin
        if (b == jsu_pkg::CH_BSLASH) begin
          dec_mode = DM_PENDU;
        end else begin
          flush_high();
          dec_mode = DM_BODY;
          body_byte(b);
        end
      end
      DM_PENDU: begin
        if (b == jsu_pkg::CH_U) begin
          dec_mode  = DM_LOWHEX;
          dec_hex_n = '0;
          dec_code  = '0;
        end else begin
          flush_high();
          dec_mode = DM_BODY;
          esc_byte(b);
        end
      end
      DM_LOWHEX: begin
        v = hex_digit(b);
        if (v < 0) begin
          flush_high();
          fail_to(jsu_pkg::ST_BAD_UNI);
        end else begin
          dec_code = {dec_code[11:0], 4'(v)};
          if (dec_hex_n != 2'd3) begin
            dec_hex_n++;
          end else if (dec_code >= 16'hDC00 && dec_code <= 16'hDFFF) begin
            put_utf8(21'h10000 + {1'b0, dec_high, dec_code[9:0]});
            dec_mode = DM_BODY;
          end else begin
            flush_high();
            finish_code(dec_code);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void end_text();
    case (dec_mode)
      DM_IDLE:   put_res(8'h00, jsu_pkg::ST_NO_QUOTE);
      DM_BODY:   put_res(8'h00, jsu_pkg::ST_UNTERM);
      DM_ESC:    put_res(8'h00, jsu_pkg::ST_UNT_ESC);
      DM_HEX:    put_res(8'h00, jsu_pkg::ST_BAD_UNI);
      DM_PEND: begin
        flush_high();
        put_res(8'h00, jsu_pkg::ST_UNTERM);
      end
      DM_PENDU: begin
        flush_high();
        put_res(8'h00, jsu_pkg::ST_UNT_ESC);
      end
      DM_LOWHEX: begin
        flush_high();
        put_res(8'h00, jsu_pkg::ST_BAD_UNI);
      end
      default: ;
    endcase
    dec_mode  = DM_IDLE;
    dec_hex_n = '0;
    dec_code  = '0;
    dec_high  = '0;
  endfunction

  function automatic void unescape_step(input text_item_t it);
    step_q.delete();
    if (it.kind == KIND_END) end_text();
    else text_in(it.b);
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
  endfunction

  // stimulus building

  function automatic dir_row_t plain_row(input logic k, input logic [7:0] b);
    dir_row_t r;
    r = '0;
    r.item.kind = k;
    r.item.b    = b;
    return r;
  endfunction

  function automatic dir_row_t typed_row(input logic k, input logic [7:0] b,
                                         input logic [7:0] d, input jsu_pkg::status_e s);
    dir_row_t r;
    r = plain_row(k, b);
    r.typed     = 1'b1;
    r.want.data = d;
    r.want.st   = s;
    r.want.last = 1'b1;
    return r;
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    text_item_t it;
    it.kind = KIND_BYTE;
    it.b    = b;
    text_q  = {text_q, it};
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
  endfunction

  function automatic void add_u(input logic [15:0] code);
    push_byte(jsu_pkg::CH_BSLASH);
    push_byte(jsu_pkg::CH_U);
    for (int i = 3; i >= 0; i--) push_byte(hex_char(code[i*4 +: 4]));
  endfunction

  function automatic void add_token(input bit tidy);
    logic [7:0]  b;
    logic [7:0]  ch;
    logic [15:0] code;
    case ($urandom_range(0, tidy ? 12 : 15))
      0, 1, 2, 3, 4: begin
        do b = 8'($urandom_range(0, 255));
        while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
        push_byte(b);
      end
      5, 6: begin
        push_byte(jsu_pkg::CH_BSLASH);
        push_byte(ESC_LIST[$urandom_range(0, 7)]);
      end
      7, 8: begin
        case ($urandom_range(0, 3))
          0: code = 16'($urandom_range(0, 'h7F));
          1: code = 16'($urandom_range('h80, 'h7FF));
          2: code = 16'($urandom_range('h800, 'hFFFF));
          default: code = 16'($urandom_range('hDC00, 'hDFFF));
        endcase
        add_u(code);
      end
      9, 10: begin
        add_u(16'($urandom_range('hD800, 'hDBFF)));
        add_u(16'($urandom_range('hDC00, 'hDFFF)));
      end
      11: begin
        add_u(16'($urandom_range('hD800, 'hDBFF)));
        do code = 16'($urandom_range(0, 'hFFFF)); while (code >= 16'hDC00 && code <= 16'hDFFF);
        add_u(code);
      end
      12: add_u(16'($urandom_range('hD800, 'hDBFF)));
      13: begin
        do b = 8'($urandom_range(0, 255)); while (simple_escape(b, ch) || b == jsu_pkg::CH_U);
        push_byte(jsu_pkg::CH_BSLASH);
        push_byte(b);
      end
      14: begin
        push_byte(jsu_pkg::CH_BSLASH);
        push_byte(jsu_pkg::CH_U);
        repeat ($urandom_range(0, 3)) push_byte(hex_char(4'($urandom_range(0, 15))));
        do b = 8'($urandom_range(0, 255)); while (hex_digit(b) >= 0);
        push_byte(b);
      end
      default: push_byte(8'($urandom_range(0, 'h1F)));
    endcase
  endfunction

  // one JSON text: mostly a quoted string, sometimes noise, unterminated or cut short
  function automatic void build_text(input int n_tok, input bit tidy);
    int shape;
    int ending;
    int keep;
    text_item_t it;
    text_q.delete();
    shape = tidy ? 1 : $urandom_range(0, 9);
    if (shape == 0) begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
    end else begin
      push_byte(jsu_pkg::CH_QUOTE);
      repeat (n_tok) add_token(tidy);
      ending = tidy ? 0 : $urandom_range(0, 9);
      if (ending < 7) begin
        push_byte(jsu_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
      end else if (ending == 9) begin
        keep = $urandom_range(1, text_q.size());
        while (text_q.size() > keep) void'(text_q.pop_back());
      end
    end
    it.kind = KIND_END;
    it.b    = 8'($urandom_range(0, 255));
    text_q  = {text_q, it};
  endfunction

  task automatic send_text(input text_item_t it, input logic typed, input dec_res_t want);
    int gap;
    gap = draw_gap(tx_quiet);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.kind    = it.kind;
    in_ch.in_byte = it.b;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
    unescape_step(it);
    if (typed) begin
      step_q.delete();
      step_q = {step_q, want};
    end
    decoded_q = {decoded_q, step_q};
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  // output ready
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ch.ready = 1'b0;
        rx_hold--;
      end else if (rx_wait > 0) begin
        out_ch.ready = 1'b0;
        rx_wait--;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // result checker
  initial begin
    dec_res_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          n_bad++;
          if (n_bad <= MAX_REPORT)
            $display("unexpected transfer: byte %02h status %0d last %0b",
                     out_ch.out_byte, out_ch.status, out_ch.last);
        end else begin
          want = decoded_q.pop_front();
          if (out_ch.out_byte !== want.data || out_ch.status !== want.st ||
              out_ch.last !== want.last) begin
            n_bad++;
            if (n_bad <= MAX_REPORT)
              $display("mismatch: exp %02h/%0d/%0b got %02h/%0d/%0b",
                       want.data, want.st, want.last,
                       out_ch.out_byte, out_ch.status, out_ch.last);
          end
        end
        rx_wait = draw_gap(rx_quiet);
      end
    end
  end

  initial begin
    while (n_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      n_cycles++;
    end
    $display("json_string_unescape_utf8 regression: fail");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.kind    = KIND_BYTE;
    in_ch.in_byte = 8'h00;
    out_ch.ready  = 1'b0;
    dir_tab = '{
      typed_row(KIND_END,  8'hA5, 8'h00, jsu_pkg::ST_NO_QUOTE),
      typed_row(KIND_BYTE, 8'h61, 8'h00, jsu_pkg::ST_NO_QUOTE),
      plain_row(KIND_BYTE, 8'hFF),
      plain_row(KIND_END,  8'h00),
      plain_row(KIND_BYTE, jsu_pkg::CH_QUOTE),
      typed_row(KIND_BYTE, 8'h00, 8'h00, jsu_pkg::ST_BYTE),
      typed_row(KIND_BYTE, 8'hFF, 8'hFF, jsu_pkg::ST_BYTE),
      plain_row(KIND_BYTE, jsu_pkg::CH_BSLASH),
      typed_row(KIND_BYTE, 8'h71, 8'h00, jsu_pkg::ST_BAD_ESC),
      plain_row(KIND_END,  8'hFF),
      plain_row(KIND_BYTE, jsu_pkg::CH_QUOTE),
      plain_row(KIND_BYTE, jsu_pkg::CH_BSLASH),
      plain_row(KIND_BYTE, jsu_pkg::CH_U),
      plain_row(KIND_BYTE, 8'h44),
      plain_row(KIND_BYTE, 8'h38),
      plain_row(KIND_BYTE, 8'h30),
      plain_row(KIND_BYTE, 8'h30),
      plain_row(KIND_BYTE, jsu_pkg::CH_BSLASH),
      plain_row(KIND_BYTE, jsu_pkg::CH_U),
      plain_row(KIND_BYTE, 8'h64),
      plain_row(KIND_BYTE, 8'h66),
      plain_row(KIND_BYTE, 8'h66),
      plain_row(KIND_BYTE, 8'h66),
      typed_row(KIND_BYTE, jsu_pkg::CH_QUOTE, 8'h00, jsu_pkg::ST_DONE),
      plain_row(KIND_END,  8'h5A)
    };
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) send_text(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
    wait_drained();

    // output stalled while input keeps coming: queue fills, input backs up
    rx_hold  = LONG_HOLD;
    tx_quiet = 1'b1;
    build_text(10, 1'b1);
    foreach (text_q[i]) send_text(text_q[i], 1'b0, '0);
    wait_drained();

    while (n_sent < N_ITEMS) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      build_text($urandom_range(0, 6), 1'b0);
      foreach (text_q[i]) send_text(text_q[i], 1'b0, '0);
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_bad == 0 && decoded_q.size() == 0) begin
      $display("json_string_unescape_utf8 regression: pass");
    end else begin
      $display("json_string_unescape_utf8 regression: fail");
    end
    $finish;
  end

endmodule
